// File: sv/pott_pkg.sv
package pott_pkg;

    // Field widths fixed by the interface.
    localparam int ACT_W   = 2;
    localparam int ID_W    = 32;
    localparam int IVL_W   = 32;
    localparam int TIME_W  = 40;
    localparam int EV_W    = 2;
    localparam int ST_W    = 2;
    localparam int CNT_W   = 5;

    // Default table depth.
    localparam int MAX_ENTRIES_DEF = 16;

    // Request action codes.
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

    // Result event codes.
    localparam logic [EV_W-1:0] EV_FIRED       = 2'd0;
    localparam logic [EV_W-1:0] EV_ADD_DONE    = 2'd1;
    localparam logic [EV_W-1:0] EV_REMOVE_DONE = 2'd2;
    localparam logic [EV_W-1:0] EV_TICK_DONE   = 2'd3;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

    // One stored timer entry, as one memory word.
    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic              is_periodic;
        logic              enabled;
        logic              delete_flag;
        logic [IVL_W-1:0]  interval;
        logic [TIME_W-1:0] next_time;
    } t_entry;

    // Decision for one entry visited by a walk.
    typedef struct packed {
        logic              fire;
        logic              drop;
        logic              keep;
        t_entry            wdata;
        logic [TIME_W-1:0] next_time;
    } t_upd;

    // Time plus interval, saturating at the top of the time range.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [IVL_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W + 1 - IVL_W){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

// File: sv/pott_mem.sv
module pott_mem #(
    parameter int DEPTH = pott_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rd_en,
    input  logic [AW-1:0]          i_rd_addr,
    output pott_pkg::t_entry       o_rd_data,
    input  logic                   i_wr_en,
    input  logic [AW-1:0]          i_wr_addr,
    input  pott_pkg::t_entry       i_wr_data
);

    pott_pkg::t_entry mem [DEPTH];
    pott_pkg::t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/pott_upd.sv
module pott_upd (
    input  logic                          i_remove,
    input  logic                          i_found,
    input  logic [pott_pkg::ID_W-1:0]     i_job_id,
    input  logic [pott_pkg::TIME_W-1:0]   i_now,
    input  pott_pkg::t_entry              i_entry,
    output pott_pkg::t_upd                o_upd
);

    logic                          match;
    logic                          due;
    logic [pott_pkg::TIME_W-1:0]   resched;

    assign match   = !i_found && (i_entry.ident == i_job_id);
    assign due     = i_entry.enabled && (i_entry.next_time != '0) &&
                     (i_entry.next_time <= i_now);
    assign resched = pott_pkg::sat_add(i_now, i_entry.interval);

    // Decide whether the entry fires, is dropped, or is written back.
    always_comb begin
        o_upd.fire      = 1'b0;
        o_upd.drop      = 1'b0;
        o_upd.keep      = 1'b1;
        o_upd.wdata     = i_entry;
        o_upd.next_time = '0;
        if (i_remove) begin
            // The first matching entry is removed; the rest shift down.
            o_upd.drop = match;
            o_upd.keep = !match;
        end else if (due) begin
            o_upd.fire = 1'b1;
            if (i_entry.is_periodic) begin
                o_upd.wdata.next_time = resched;
                o_upd.next_time       = resched;
            end else if (i_entry.delete_flag) begin
                o_upd.drop = 1'b1;
                o_upd.keep = 1'b0;
            end else begin
                o_upd.wdata.enabled   = 1'b0;
                o_upd.wdata.next_time = '0;
            end
        end
    end

endmodule

// File: sv/periodic_one_shot_timer_table.sv
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready    action, job_id, periodic, interval,
//                                                 at_time, delete_after_fire, now
// result    out        o_out_valid / i_out_ready  event_res, status, fired_id,
//                                                 next_time, entries_in_use, last
//
// An add writes the new entry in the S_ADD state. A remove or a tick walks the N entries
// in use: every entry takes a memory read (S_RD) and an evaluate/write-back step (S_EV)
// on the single-port-pair table memory.
// Reset clears the entry count and the control state; the table memory is not cleared.
// A request is taken only when the sequencer is idle. A pending result that is not
// taken stalls an add, the walk at the next entry that fires, or the final result.
module periodic_one_shot_timer_table #(
    parameter int MAX_ENTRIES = pott_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [pott_pkg::ACT_W-1:0]      i_action,
    input  logic [pott_pkg::ID_W-1:0]       i_job_id,
    input  logic                            i_periodic,
    input  logic [pott_pkg::IVL_W-1:0]      i_interval,
    input  logic [pott_pkg::TIME_W-1:0]     i_at_time,
    input  logic                            i_delete_after_fire,
    input  logic [pott_pkg::TIME_W-1:0]     i_now,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pott_pkg::EV_W-1:0]       o_event_res,
    output logic [pott_pkg::ST_W-1:0]       o_status,
    output logic [pott_pkg::ID_W-1:0]       o_fired_id,
    output logic [pott_pkg::TIME_W-1:0]     o_next_time,
    output logic [pott_pkg::CNT_W-1:0]      o_entries_in_use,
    output logic                            o_last
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EV   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // Sequencer and table bookkeeping.
    logic [2:0]                     r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic [CW-1:0]                  r_rd, n_rd;
    logic [CW-1:0]                  r_wr, n_wr;
    logic [CW-1:0]                  r_end, n_end;
    logic                           r_found, n_found;

    // Captured request.
    logic [pott_pkg::ACT_W-1:0]     r_action;
    logic [pott_pkg::ID_W-1:0]      r_job_id;
    logic                           r_periodic;
    logic [pott_pkg::IVL_W-1:0]     r_interval;
    logic [pott_pkg::TIME_W-1:0]    r_at_time;
    logic                           r_delete;
    logic [pott_pkg::TIME_W-1:0]    r_now;

    // Result register.
    logic                           r_o_valid;
    logic [pott_pkg::EV_W-1:0]      r_o_event;
    logic [pott_pkg::ST_W-1:0]      r_o_status;
    logic [pott_pkg::ID_W-1:0]      r_o_id;
    logic [pott_pkg::TIME_W-1:0]    r_o_next;
    logic [pott_pkg::CNT_W-1:0]     r_o_count;
    logic                           r_o_last;

    logic                           load;
    logic [pott_pkg::EV_W-1:0]      ld_event;
    logic [pott_pkg::ST_W-1:0]      ld_status;
    logic [pott_pkg::ID_W-1:0]      ld_id;
    logic [pott_pkg::TIME_W-1:0]    ld_next;
    logic                           ld_last;
    logic [CW+pott_pkg::CNT_W-1:0]  cnt_ext;

    logic                           in_acc;
    logic                           out_free;
    logic                           is_remove;
    logic                           full;

    logic                           mem_re;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    pott_pkg::t_entry               mem_wdata;
    pott_pkg::t_entry               mem_rdata;
    pott_pkg::t_entry               add_entry;
    pott_pkg::t_upd                 upd;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_o_valid || i_out_ready;
    assign is_remove  = (r_action == pott_pkg::ACT_REMOVE);
    assign full       = (r_count >= CW'(MAX_ENTRIES));

    // Entry built by an add.
    always_comb begin
        add_entry.ident       = r_job_id;
        add_entry.is_periodic = r_periodic;
        add_entry.enabled     = 1'b1;
        add_entry.delete_flag = r_delete;
        add_entry.interval    = r_interval;
        add_entry.next_time   = '0;
        if (r_periodic) begin
            add_entry.next_time = pott_pkg::sat_add(r_now, r_interval);
        end else if (r_at_time > r_now) begin
            add_entry.next_time = r_at_time;
        end else begin
            add_entry.enabled = 1'b0;
        end
    end

    pott_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_re),
        .i_rd_addr (r_rd[AW-1:0]),
        .o_rd_data (mem_rdata),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata)
    );

    pott_upd u_upd (
        .i_remove (is_remove),
        .i_found  (r_found),
        .i_job_id (r_job_id),
        .i_now    (r_now),
        .i_entry  (mem_rdata),
        .o_upd    (upd)
    );

    // Sequencer: add, or walk the table with a read and a write pointer.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_end     = r_end;
        n_found   = r_found;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_wr[AW-1:0];
        mem_wdata = upd.wdata;
        load      = 1'b0;
        ld_event  = pott_pkg::EV_TICK_DONE;
        ld_status = pott_pkg::ST_OK;
        ld_id     = '0;
        ld_next   = '0;
        ld_last   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_rd    = '0;
                    n_wr    = '0;
                    n_end   = r_count;
                    n_found = 1'b0;
                    if (i_action == pott_pkg::ACT_ADD) begin
                        n_state = S_ADD;
                    end else if ((i_action inside {pott_pkg::ACT_REMOVE, pott_pkg::ACT_TICK})
                                 && r_count != '0) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_ADD: begin
                if (out_free) begin
                    load     = 1'b1;
                    ld_event = pott_pkg::EV_ADD_DONE;
                    ld_id    = r_job_id;
                    ld_last  = 1'b1;
                    if (full) begin
                        ld_status = pott_pkg::ST_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[AW-1:0];
                        mem_wdata = add_entry;
                        n_count   = r_count + 1'b1;
                        ld_next   = add_entry.next_time;
                    end
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_EV;
            end
            S_EV: begin
                // A firing entry waits here until the result register is free.
                if (!upd.fire || out_free) begin
                    if (upd.keep) begin
                        mem_we = 1'b1;
                        n_wr   = r_wr + 1'b1;
                    end
                    if (upd.drop) begin
                        n_count = r_count - 1'b1;
                        n_found = 1'b1;
                    end
                    if (upd.fire) begin
                        load     = 1'b1;
                        ld_event = pott_pkg::EV_FIRED;
                        ld_id    = mem_rdata.ident;
                        ld_next  = upd.next_time;
                    end
                    n_rd    = r_rd + 1'b1;
                    n_state = (n_rd == r_end) ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_last = 1'b1;
                    if (is_remove) begin
                        ld_event  = pott_pkg::EV_REMOVE_DONE;
                        ld_id     = r_job_id;
                        ld_status = r_found ? pott_pkg::ST_OK : pott_pkg::ST_NOT_FOUND;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign cnt_ext = {{pott_pkg::CNT_W{1'b0}}, n_count};

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd      <= '0;
            r_wr      <= '0;
            r_end     <= '0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_end   <= n_end;
            r_found <= n_found;
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action   <= i_action;
            r_job_id   <= i_job_id;
            r_periodic <= i_periodic;
            r_interval <= i_interval;
            r_at_time  <= i_at_time;
            r_delete   <= i_delete_after_fire;
            r_now      <= i_now;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_event  <= ld_event;
            r_o_status <= ld_status;
            r_o_id     <= ld_id;
            r_o_next   <= ld_next;
            r_o_count  <= cnt_ext[pott_pkg::CNT_W-1:0];
            r_o_last   <= ld_last;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_event_res      = r_o_event;
    assign o_status         = r_o_status;
    assign o_fired_id       = r_o_id;
    assign o_next_time      = r_o_next;
    assign o_entries_in_use = r_o_count;
    assign o_last           = r_o_last;

    // The table never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count exceeds table depth");

    // Compaction writes never run ahead of the read pointer.
    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EV |-> r_wr <= r_rd)
        else $error("write pointer passed read pointer");

    // Only an add or a walk step changes the entry count.
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ADD && r_state != S_EV) |=> r_count == $past(r_count))
        else $error("entry count changed outside add or walk");

    // A fired result is never the final result of a request.
    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res == pott_pkg::EV_FIRED |-> !o_last)
        else $error("fired result marked last");

endmodule

// File: tb/tb_top.sv
module tb_top;

    localparam int DEPTH = pott_pkg::MAX_ENTRIES_DEF;
    localparam logic [pott_pkg::TIME_W-1:0] TOP_TIME = '1;
    // The one action code that has no defined request.
    localparam logic [pott_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    // One request as driven on the input channel.
    typedef struct {
        logic [pott_pkg::ACT_W-1:0]  action;
        logic [pott_pkg::ID_W-1:0]   job_id;
        logic                        periodic;
        logic [pott_pkg::IVL_W-1:0]  interval;
        logic [pott_pkg::TIME_W-1:0] at_time;
        logic                        del_after;
        logic [pott_pkg::TIME_W-1:0] now_t;
    } t_timer_req;

    // One result as seen on the output channel.
    typedef struct {
        logic [pott_pkg::EV_W-1:0]   ev;
        logic [pott_pkg::ST_W-1:0]   st;
        logic [pott_pkg::ID_W-1:0]   id;
        logic [pott_pkg::TIME_W-1:0] nt;
        logic [pott_pkg::CNT_W-1:0]  cnt;
        logic                        last;
    } t_timer_result;

    // One timer entry as tracked by the predictor.
    typedef struct {
        logic [pott_pkg::ID_W-1:0]   ident;
        logic                        periodic;
        logic                        enabled;
        logic                        del_after;
        logic [pott_pkg::IVL_W-1:0]  interval;
        logic [pott_pkg::TIME_W-1:0] next_at;
    } t_timer_slot;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [pott_pkg::ACT_W-1:0]    i_action;
    logic [pott_pkg::ID_W-1:0]     i_job_id;
    logic                          i_periodic;
    logic [pott_pkg::IVL_W-1:0]    i_interval;
    logic [pott_pkg::TIME_W-1:0]   i_at_time;
    logic                          i_delete_after_fire;
    logic [pott_pkg::TIME_W-1:0]   i_now;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic [pott_pkg::EV_W-1:0]     o_event_res;
    logic [pott_pkg::ST_W-1:0]     o_status;
    logic [pott_pkg::ID_W-1:0]     o_fired_id;
    logic [pott_pkg::TIME_W-1:0]   o_next_time;
    logic [pott_pkg::CNT_W-1:0]    o_entries_in_use;
    logic                          o_last;

    // Predicted table contents and the results still owed by the block.
    t_timer_slot                   slots [DEPTH];
    int unsigned                   slot_count;
    t_timer_result                 owed_results [$];

    int unsigned                   mismatches;
    bit                            tx_gaps;
    bit                            rx_gaps;
    int unsigned                   rx_hold_cycles;
    logic [pott_pkg::TIME_W-1:0]   wall_now;
    t_timer_result                 want_r;
    t_timer_result                 got_r;

    periodic_one_shot_timer_table #(
        .MAX_ENTRIES(DEPTH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_job_id           (i_job_id),
        .i_periodic         (i_periodic),
        .i_interval         (i_interval),
        .i_at_time          (i_at_time),
        .i_delete_after_fire(i_delete_after_fire),
        .i_now              (i_now),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_event_res        (o_event_res),
        .o_status           (o_status),
        .o_fired_id         (o_fired_id),
        .o_next_time        (o_next_time),
        .o_entries_in_use   (o_entries_in_use),
        .o_last             (o_last)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Hard limit on the run time.
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Time plus interval, clamped at the top of the time range.
    function automatic logic [pott_pkg::TIME_W-1:0] later_by(
            input logic [pott_pkg::TIME_W-1:0] base,
            input logic [pott_pkg::IVL_W-1:0] ivl);
        logic [pott_pkg::TIME_W:0] sum;
        sum = {1'b0, base} + {{(pott_pkg::TIME_W + 1 - pott_pkg::IVL_W){1'b0}}, ivl};
        return sum[pott_pkg::TIME_W] ? TOP_TIME : sum[pott_pkg::TIME_W-1:0];
    endfunction

    function automatic logic [pott_pkg::TIME_W-1:0] rand_time();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[pott_pkg::TIME_W-1:0];
    endfunction

    function automatic void owe_result(input logic [pott_pkg::EV_W-1:0] ev,
                                       input logic [pott_pkg::ST_W-1:0] st,
                                       input logic [pott_pkg::ID_W-1:0] id,
                                       input logic [pott_pkg::TIME_W-1:0] nt,
                                       input logic last);
        t_timer_result r;
        r.ev   = ev;
        r.st   = st;
        r.id   = id;
        r.nt   = nt;
        r.cnt  = slot_count[pott_pkg::CNT_W-1:0];
        r.last = last;
        owed_results.push_back(r);
    endfunction

    // Remove one entry and close the gap behind it.
    function automatic void drop_slot(input int unsigned idx);
        int unsigned j;
        for (j = idx; j + 1 < slot_count; j++) begin
            slots[j] = slots[j + 1];
        end
        slot_count--;
    endfunction

    // Update the predicted table for one accepted request and queue its results.
    function automatic void predict_timer_request(input t_timer_req r);
        logic [pott_pkg::TIME_W-1:0] nt;
        logic [pott_pkg::ID_W-1:0]   fid;
        int unsigned                 i;
        bit                          found;
        case (r.action)
            pott_pkg::ACT_ADD: begin
                if (slot_count >= DEPTH) begin
                    owe_result(pott_pkg::EV_ADD_DONE, pott_pkg::ST_FULL, r.job_id, '0, 1'b1);
                end else begin
                    slots[slot_count].ident     = r.job_id;
                    slots[slot_count].periodic  = r.periodic;
                    slots[slot_count].del_after = r.del_after;
                    slots[slot_count].interval  = r.interval;
                    slots[slot_count].enabled   = 1'b1;
                    if (r.periodic) begin
                        nt = later_by(r.now_t, r.interval);
                    end else if (r.at_time > r.now_t) begin
                        nt = r.at_time;
                    end else begin
                        // A one-shot time already passed is stored but never fires.
                        nt = '0;
                        slots[slot_count].enabled = 1'b0;
                    end
                    slots[slot_count].next_at = nt;
                    slot_count++;
                    owe_result(pott_pkg::EV_ADD_DONE, pott_pkg::ST_OK, r.job_id, nt, 1'b1);
                end
            end
            pott_pkg::ACT_REMOVE: begin
                found = 1'b0;
                for (i = 0; i < slot_count && !found; i++) begin
                    if (slots[i].ident == r.job_id) begin
                        drop_slot(i);
                        found = 1'b1;
                    end
                end
                owe_result(pott_pkg::EV_REMOVE_DONE,
                           found ? pott_pkg::ST_OK : pott_pkg::ST_NOT_FOUND,
                           r.job_id, '0, 1'b1);
            end
            pott_pkg::ACT_TICK: begin
                // Fire every due entry in table order, then close with a tick result.
                i = 0;
                while (i < slot_count) begin
                    nt  = slots[i].next_at;
                    fid = slots[i].ident;
                    if (!slots[i].enabled || nt == '0 || nt > r.now_t) begin
                        i++;
                        continue;
                    end
                    if (slots[i].periodic) begin
                        nt = later_by(r.now_t, slots[i].interval);
                        slots[i].next_at = nt;
                        i++;
                    end else if (slots[i].del_after) begin
                        drop_slot(i);
                        nt = '0;
                    end else begin
                        slots[i].enabled = 1'b0;
                        slots[i].next_at = '0;
                        nt = '0;
                        i++;
                    end
                    owe_result(pott_pkg::EV_FIRED, pott_pkg::ST_OK, fid, nt, 1'b0);
                end
                owe_result(pott_pkg::EV_TICK_DONE, pott_pkg::ST_OK, '0, '0, 1'b1);
            end
            default: begin
                // The unused action code leaves the table alone.
                owe_result(pott_pkg::EV_TICK_DONE, pott_pkg::ST_OK, '0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic t_timer_req make_request(
            input logic [pott_pkg::ACT_W-1:0] action,
            input logic [pott_pkg::ID_W-1:0] job_id,
            input logic periodic,
            input logic [pott_pkg::IVL_W-1:0] interval,
            input logic [pott_pkg::TIME_W-1:0] at_time,
            input logic del_after,
            input logic [pott_pkg::TIME_W-1:0] now_t);
        t_timer_req r;
        r.action    = action;
        r.job_id    = job_id;
        r.periodic  = periodic;
        r.interval  = interval;
        r.at_time   = at_time;
        r.del_after = del_after;
        r.now_t     = now_t;
        return r;
    endfunction

    // Drive one request, wait for it to be taken, then maybe leave a gap.
    task automatic send_request(input t_timer_req r);
        int gap;
        @(negedge i_clk);
        i_in_valid          <= 1'b1;
        i_action            <= r.action;
        i_job_id            <= r.job_id;
        i_periodic          <= r.periodic;
        i_interval          <= r.interval;
        i_at_time           <= r.at_time;
        i_delete_after_fire <= r.del_after;
        i_now               <= r.now_t;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_timer_request(r);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Mostly well-formed traffic on a slowly advancing clock, with some noise.
    function automatic t_timer_req random_request();
        t_timer_req  r;
        int unsigned pick;
        pick        = $urandom_range(0, 99);
        r.job_id    = $urandom();
        r.periodic  = 1'($urandom_range(0, 1));
        r.interval  = $urandom();
        r.at_time   = rand_time();
        r.del_after = 1'($urandom_range(0, 1));
        r.now_t     = wall_now;
        if (pick < 40) begin
            r.action = pott_pkg::ACT_ADD;
            if ($urandom_range(0, 3) != 0) r.job_id = $urandom_range(0, 15);
            if ($urandom_range(0, 9) != 0) r.interval = $urandom_range(1, 20);
            case ($urandom_range(0, 9))
                7, 8:    r.at_time = wall_now - $urandom_range(0, 20);
                9:       ;
                default: r.at_time = wall_now + $urandom_range(1, 25);
            endcase
        end else if (pick < 65) begin
            r.action = pott_pkg::ACT_REMOVE;
            if (slot_count > 0 && $urandom_range(0, 4) != 0) begin
                r.job_id = slots[$urandom_range(0, slot_count - 1)].ident;
            end else if ($urandom_range(0, 1) != 0) begin
                r.job_id = $urandom_range(0, 15);
            end
            r.now_t = rand_time();
        end else begin
            r.action = pott_pkg::ACT_TICK;
            wall_now = wall_now + $urandom_range(0, 6);
            r.now_t  = ($urandom_range(0, 39) == 0) ? rand_time() : wall_now;
        end
        return r;
    endfunction

    // Check every taken result against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_r.ev   = o_event_res;
            got_r.st   = o_status;
            got_r.id   = o_fired_id;
            got_r.nt   = o_next_time;
            got_r.cnt  = o_entries_in_use;
            got_r.last = o_last;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: ev=%0d st=%0d id=%h next=%h cnt=%0d last=%0b",
                             got_r.ev, got_r.st, got_r.id, got_r.nt, got_r.cnt, got_r.last);
                end
            end else begin
                want_r = owed_results.pop_front();
                if (got_r.ev !== want_r.ev || got_r.st !== want_r.st
                        || got_r.id !== want_r.id || got_r.nt !== want_r.nt
                        || got_r.cnt !== want_r.cnt || got_r.last !== want_r.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp ev=%0d st=%0d id=%h next=%h cnt=%0d last=%0b",
                                 want_r.ev, want_r.st, want_r.id, want_r.nt, want_r.cnt,
                                 want_r.last);
                        $display("          got ev=%0d st=%0d id=%h next=%h cnt=%0d last=%0b",
                                 got_r.ev, got_r.st, got_r.id, got_r.nt, got_r.cnt,
                                 got_r.last);
                    end
                end
            end
        end
    end

    // Result side: random stalls, or one long hold-off when a test asks for it.
    initial begin
        int n;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 10);
                i_out_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Edge values and every special case, on a small hand-built table.
    task automatic test_directed_cases();
        send_request(make_request(pott_pkg::ACT_REMOVE, '0, 1'b0, '0, '0, 1'b0, '0));
        send_request(make_request(pott_pkg::ACT_TICK, '0, 1'b0, '0, '0, 1'b0, '0));
        // Periodic entry that saturates at the top of the time range.
        send_request(make_request(pott_pkg::ACT_ADD, '1, 1'b1, '1, '0, 1'b0, TOP_TIME));
        // Zero interval at time zero gives a next time of zero, so it never fires.
        send_request(make_request(pott_pkg::ACT_ADD, '0, 1'b1, '0, '0, 1'b0, '0));
        // One-shot entries: already past, deleted on fire, disabled on fire.
        send_request(make_request(pott_pkg::ACT_ADD, 32'd1, 1'b0, '0, '0, 1'b1, '0));
        send_request(make_request(pott_pkg::ACT_ADD, 32'd2, 1'b0, '0, 40'd100, 1'b1,
                                  40'd10));
        send_request(make_request(pott_pkg::ACT_ADD, 32'd3, 1'b0, '0, 40'd100, 1'b0,
                                  40'd10));
        send_request(make_request(pott_pkg::ACT_ADD, 32'd4, 1'b1, '0, '0, 1'b0, 40'd50));
        send_request(make_request(pott_pkg::ACT_ADD, 32'd5, 1'b0, '0, 40'd100, 1'b0,
                                  40'd100));
        send_request(make_request(pott_pkg::ACT_ADD, 32'd6, 1'b1, 32'd7, TOP_TIME, 1'b1,
                                  40'd60));
        send_request(make_request(pott_pkg::ACT_TICK, '1, 1'b1, '1, '1, 1'b1, 40'd99));
        send_request(make_request(pott_pkg::ACT_TICK, '0, 1'b0, '0, '0, 1'b0, 40'd100));
        // The unused action code only closes with a tick result.
        send_request(make_request(ACT_UNUSED, 32'd9, 1'b1, 32'd3, 40'd5, 1'b1, 40'd1000));
        // The zero-interval entry was rescheduled to now and fires again.
        send_request(make_request(pott_pkg::ACT_TICK, '0, 1'b0, '0, '0, 1'b0, 40'd100));
        // Duplicate ids: a remove takes the first match.
        send_request(make_request(pott_pkg::ACT_ADD, 32'd7, 1'b0, '0, 40'd200, 1'b0,
                                  40'd100));
        send_request(make_request(pott_pkg::ACT_ADD, 32'd7, 1'b1, 32'd3, '0, 1'b0,
                                  40'd100));
        send_request(make_request(pott_pkg::ACT_REMOVE, 32'd7, 1'b0, '0, '0, 1'b0, '0));
        send_request(make_request(pott_pkg::ACT_REMOVE, 32'hDEAD_BEEF, 1'b1, '1, '1, 1'b1,
                                  '1));
        send_request(make_request(pott_pkg::ACT_TICK, '0, 1'b0, '0, '0, 1'b0, TOP_TIME));
        send_request(make_request(pott_pkg::ACT_REMOVE, '1, 1'b0, '0, '0, 1'b0, '0));
    endtask

    // Fill the table while results are held back, then overflow it.
    task automatic test_full_table_backpressure();
        int k;
        rx_hold_cycles = 400;
        k = 0;
        while (slot_count < DEPTH || k < 2) begin
            if (slot_count >= DEPTH) k++;
            send_request(make_request(pott_pkg::ACT_ADD, $urandom_range(16, 31),
                                      1'($urandom_range(0, 1)),
                                      $urandom_range(1, 5), wall_now + $urandom_range(1, 5),
                                      1'($urandom_range(0, 1)), wall_now));
        end
        wall_now = wall_now + 5;
        send_request(make_request(pott_pkg::ACT_TICK, '0, 1'b0, '0, '0, 1'b0, wall_now));
        wall_now = wall_now + 5;
        send_request(make_request(pott_pkg::ACT_TICK, '0, 1'b0, '0, '0, 1'b0, wall_now));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_request(random_request());
    endtask

    // Closing stretch with both sides always willing.
    task automatic test_steady_stream(input int count);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (count) send_request(random_request());
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_action            = pott_pkg::ACT_ADD;
        i_job_id            = '0;
        i_periodic          = 1'b0;
        i_interval          = '0;
        i_at_time           = '0;
        i_delete_after_fire = 1'b0;
        i_now               = '0;
        slot_count          = 0;
        mismatches          = 0;
        tx_gaps             = 1'b1;
        rx_gaps             = 1'b1;
        rx_hold_cycles      = 0;
        wall_now            = 40'd1000;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_full_table_backpressure();
        test_random_traffic(170);
        test_steady_stream(30);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
sv/pott_pkg.sv
sv/pott_mem.sv
sv/pott_upd.sv
sv/periodic_one_shot_timer_table.sv
tb/tb_top.sv
